@@ hw/rtl/mbrtu_pkg.sv @@
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Shared constants and the byte-wide CRC-16 update for the RTU frame receiver.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

  localparam int MAX_FRAME_DEF = 256;
  localparam int MIN_FRAME     = 4;
  localparam int LEN_W         = 9;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_TIMEOUT = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TIMEOUT   = 2'd1;
  localparam logic [1:0] ST_NULL_TOUT = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef logic [1:0] status_t;

  // reflected CRC-16, one byte absorbed
  function automatic logic [15:0] crc_absorb(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/modbus_rtu_frame_receiver_unit.sv @@
// An accepted item passes the input register, then the result register.
// Throughput: one item per cycle while out_ready does not stall the result;
// the byte CRC update sits between the two registers, so nothing iterates.
// Reset: synchronous active-low rst_n clears both handshake stages and the
// frame state (count 0, CRC 0xFFFF, no leading null).
// ----------------------------------------------------------------------------
// modbus_rtu_frame_receiver_unit
// Gathers serial bytes into a frame and reports completion by CRC-16 match,
// timeout or full buffer.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_receiver_unit #(
  parameter int MAX_FRAME = mbrtu_pkg::MAX_FRAME_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_func,
  input  logic [7:0]                 in_data_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output mbrtu_pkg::status_t         out_status,
  output logic [7:0]                 out_function_code,
  output logic [mbrtu_pkg::LEN_W-1:0] out_frame_length
);
  import mbrtu_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAME + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME);
  localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_FRAME);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

  // input register
  logic       in_v_r;
  logic       func_r;
  logic [7:0] byte_r;

  // frame state
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       older_r, older_nxt;
  logic [7:0]       newer_r, newer_nxt;
  logic [7:0]       second_r, second_nxt;
  logic             null_r, null_nxt;

  // result register
  logic             out_v_r;
  status_t          status_r, status_nxt;
  logic [7:0]       fc_r, fc_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             emit;

  logic go;
  logic [CNT_W-1:0] cnt_inc;
  logic [15:0]      crc_upd;
  logic [7:0]       second_upd;

  assign go       = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || go;

  assign cnt_inc    = cnt_r + CNT_ONE;
  assign crc_upd    = (cnt_r >= CNT_TWO) ? crc_absorb(crc_r, older_r) : crc_r;
  assign second_upd = (cnt_r == CNT_ONE) ? byte_r : second_r;

  always_comb begin
    cnt_nxt    = cnt_r;
    crc_nxt    = crc_r;
    older_nxt  = older_r;
    newer_nxt  = newer_r;
    second_nxt = second_r;
    null_nxt   = null_r;
    emit       = 1'b0;
    status_nxt = ST_TIMEOUT;
    fc_nxt     = 8'h00;
    len_nxt    = '0;
    if (func_r == KIND_TIMEOUT) begin
      emit       = 1'b1;
      status_nxt = (cnt_r == '0 && null_r) ? ST_NULL_TOUT : ST_TIMEOUT;
    end else if (cnt_r == '0 && byte_r == 8'h00) begin
      null_nxt = 1'b1;
    end else begin
      cnt_nxt    = cnt_inc;
      crc_nxt    = crc_upd;
      older_nxt  = newer_r;
      newer_nxt  = byte_r;
      second_nxt = second_upd;
      null_nxt   = 1'b0;
      if (cnt_inc >= CNT_MIN && crc_upd == {byte_r, newer_r}) begin
        emit       = 1'b1;
        status_nxt = ST_OK;
        fc_nxt     = second_upd;
        len_nxt    = LEN_W'(cnt_inc);
      end else if (cnt_inc >= CNT_MAX) begin
        emit       = 1'b1;
        status_nxt = ST_FULL;
      end
    end
    if (emit) begin
      cnt_nxt    = '0;
      crc_nxt    = CRC_INIT;
      older_nxt  = 8'h00;
      newer_nxt  = 8'h00;
      second_nxt = 8'h00;
      null_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      cnt_r    <= '0;
      crc_r    <= CRC_INIT;
      older_r  <= 8'h00;
      newer_r  <= 8'h00;
      second_r <= 8'h00;
      null_r   <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (go) begin
        out_v_r  <= emit;
        cnt_r    <= cnt_nxt;
        crc_r    <= crc_nxt;
        older_r  <= older_nxt;
        newer_r  <= newer_nxt;
        second_r <= second_nxt;
        null_r   <= null_nxt;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      func_r <= in_func;
      byte_r <= in_data_byte;
    end
    if (go && emit) begin
      status_r <= status_nxt;
      fc_r     <= fc_nxt;
      len_r    <= len_nxt;
    end
  end

  assign out_valid         = out_v_r;
  assign out_status        = status_r;
  assign out_function_code = fc_r;
  assign out_frame_length  = len_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CNT_MAX) else $error("frame count reached buffer size");

  a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && status_r == ST_OK |-> len_r >= LEN_W'(MIN_FRAME))
    else $error("frame reported shorter than minimum");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && status_r != ST_OK |-> fc_r == 8'h00 && len_r == '0)
    else $error("non-frame result carries payload");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_v_r && out_v_r && !out_ready)
    else $error("input stalled without a blocked result");
`endif

endmodule

@@ tb/sv/tb_modbus_rtu_frame_receiver_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modbus_rtu_frame_receiver_unit
// Drives received bytes and timeout events into the RTU frame receiver and
// compares every reported frame, timeout and full-buffer result against a
// behavioural model of the CRC-16 framing kept in a small scoreboard class.
// Covers leading nulls, minimum and maximum frames, spoilt CRCs, line noise,
// random idling on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------

import mbrtu_pkg::*;

typedef struct packed {
  status_t                 status;
  logic [7:0]              fcode;
  logic [LEN_W-1:0]        frame_len;
} frame_result_t;

function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
  logic [15:0] acc;
  acc = crc ^ {8'h00, b};
  repeat (8) begin
    acc = acc[0] ? ((acc >> 1) ^ 16'hA001) : (acc >> 1);
  end
  return acc;
endfunction

class frame_scoreboard;
  logic [LEN_W-1:0] held_count;
  logic [15:0]      lag_crc;
  logic [7:0]       older_b;
  logic [7:0]       newer_b;
  logic [7:0]       fcode;
  bit               null_seen;
  frame_result_t    awaited[$];
  int               mismatches;
  int               per_status[4];

  function new();
    mismatches = 0;
    foreach (per_status[i]) per_status[i] = 0;
    clear();
  endfunction

  function void clear();
    held_count = '0;
    lag_crc    = CRC_INIT;
    older_b    = 8'h00;
    newer_b    = 8'h00;
    fcode      = 8'h00;
    null_seen  = 1'b0;
  endfunction

  function void await_result(status_t st, logic [7:0] fc, logic [LEN_W-1:0] len);
    frame_result_t r;
    r.status    = st;
    r.fcode     = fc;
    r.frame_len = len;
    awaited.push_back(r);
    per_status[st]++;
    clear();
  endfunction

  function void note_item(logic func, logic [7:0] b);
    if (func == KIND_TIMEOUT) begin
      await_result((held_count == 0 && null_seen) ? ST_NULL_TOUT : ST_TIMEOUT, 8'h00, '0);
      return;
    end
    if (held_count == 0 && b == 8'h00) begin
      null_seen = 1'b1;
      return;
    end
    if (held_count >= 2) lag_crc = crc16_fold(lag_crc, older_b);
    if (held_count == 1) fcode = b;
    older_b    = newer_b;
    newer_b    = b;
    held_count = held_count + 1'b1;
    null_seen  = 1'b0;
    if (held_count >= MIN_FRAME && lag_crc == {newer_b, older_b}) begin
      await_result(ST_OK, fcode, held_count);
    end else if (held_count >= MAX_FRAME_DEF) begin
      await_result(ST_FULL, 8'h00, '0);
    end
  endfunction

  function void report(string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    mismatches++;
  endfunction

  function void check_result(status_t st, logic [7:0] fc, logic [LEN_W-1:0] len);
    frame_result_t want;
    if (awaited.size() == 0) begin
      report($sformatf("unexpected result status %0d fc %02h len %0d", st, fc, len));
      return;
    end
    want = awaited.pop_front();
    if (st != want.status)
      report($sformatf("status %0d, wanted %0d", st, want.status));
    if (fc != want.fcode)
      report($sformatf("function code %02h, wanted %02h", fc, want.fcode));
    if (len != want.frame_len)
      report($sformatf("frame length %0d, wanted %0d", len, want.frame_len));
  endfunction

  function int pending();
    return awaited.size();
  endfunction
endclass

module tb_modbus_rtu_frame_receiver_unit;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             in_func = 1'b0;
  logic [7:0]       in_data_byte = 8'h00;
  logic             out_valid;
  logic             out_ready = 1'b0;
  status_t          out_status;
  logic [7:0]       out_function_code;
  logic [LEN_W-1:0] out_frame_length;

  frame_scoreboard board = new();
  bit              stall_on = 1'b1;
  int              ready_hold = 0;
  int              items_sent = 0;

  modbus_rtu_frame_receiver_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_function_code (out_function_code),
    .out_frame_length  (out_frame_length)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (stall_on && $urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, 4);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result(out_status, out_function_code, out_frame_length);
  end

  task automatic send_item(logic func, logic [7:0] b);
    if (stall_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= func;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    board.note_item(func, b);
    items_sent++;
  endtask

  task automatic send_timeout();
    send_item(KIND_TIMEOUT, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_frame(logic [7:0] addr, logic [7:0] fc, int body_len, bit spoil);
    logic [7:0]  bytes[$];
    logic [15:0] crc;
    bytes.push_back(addr);
    bytes.push_back(fc);
    repeat (body_len) bytes.push_back(8'($urandom_range(0, 255)));
    crc = CRC_INIT;
    foreach (bytes[i]) crc = crc16_fold(crc, bytes[i]);
    if (spoil) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    bytes.push_back(crc[7:0]);
    bytes.push_back(crc[15:8]);
    foreach (bytes[i]) send_item(KIND_BYTE, bytes[i]);
    if (spoil) send_timeout();
  endtask

  task automatic send_noise(int n);
    send_item(KIND_BYTE, 8'($urandom_range(1, 255)));
    repeat (n - 1) send_item(KIND_BYTE, ($urandom_range(0, 5) == 0) ? 8'h00
                                                                    : 8'($urandom_range(0, 255)));
    send_timeout();
  endtask

  task automatic random_traffic(int target);
    int  pick;
    bit  long_frame_done;
    bit  full_run_done;
    long_frame_done = 1'b0;
    full_run_done   = 1'b0;
    while (items_sent < target) begin
      stall_on = (items_sent < target - 120) && ($urandom_range(0, 3) != 0);
      if (!long_frame_done && items_sent > 250) begin
        send_frame(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)), MAX_FRAME_DEF - 4, 1'b0);
        long_frame_done = 1'b1;
      end else if (!full_run_done && items_sent > 400) begin
        send_noise(MAX_FRAME_DEF);
        full_run_done = 1'b1;
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
          if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_item(KIND_BYTE, 8'h00);
          send_frame(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
                     $urandom_range(0, 8), 1'b0);
          if ($urandom_range(0, 5) == 0) send_timeout();
        end else if (pick < 15) begin
          send_frame(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
                     $urandom_range(0, 8), 1'b1);
        end else if (pick < 18) begin
          send_noise($urandom_range(1, 6));
        end else begin
          send_timeout();
        end
      end
    end
  endtask

  initial begin
    int waited;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Short directed opening
    send_item(KIND_TIMEOUT, 8'hFF);
    send_item(KIND_BYTE, 8'h00);
    send_item(KIND_TIMEOUT, 8'h00);
    send_item(KIND_BYTE, 8'h00);
    send_item(KIND_BYTE, 8'h00);
    send_timeout();
    send_item(KIND_BYTE, 8'h00);
    send_frame(8'hFF, 8'h00, 0, 1'b0);
    send_frame(8'h01, 8'hFF, 0, 1'b0);
    send_item(KIND_BYTE, 8'h11);
    send_timeout();
    send_frame(8'h80, 8'h7F, 2, 1'b0);
    send_timeout();

    random_traffic(870);

    stall_on = 1'b0;
    in_valid <= 1'b0;
    waited = 0;
    while (board.pending() != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d results never arrived", board.pending()));

    $display("Sent %0d items: %0d good frames, %0d plain timeouts,", items_sent,
             board.per_status[ST_OK], board.per_status[ST_TIMEOUT]);
    $display("%0d timeouts after leading nulls and %0d full-buffer results.",
             board.per_status[ST_NULL_TOUT], board.per_status[ST_FULL]);
    if (board.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Run timed out");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/mbrtu_pkg.sv
hw/rtl/modbus_rtu_frame_receiver_unit.sv
tb/sv/tb_modbus_rtu_frame_receiver_unit.sv
